### rtl/text_mode_char_buffer_core_macros.svh
// Assertion macros for the character buffer checker.
// Depends on nothing; taken in by the checker file only.
`ifndef TEXT_MODE_CHAR_BUFFER_CORE_MACROS_SVH
`define TEXT_MODE_CHAR_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define TMCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is high.
`define TMCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tmcb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the character buffer.
// No dependencies.
package tmcb_pkg;

  localparam int ROWS_DEFAULT = 24;
  localparam int COLS_DEFAULT = 40;
  localparam int ROW_FIELD_W  = 5;
  localparam int COL_FIELD_W  = 6;
  localparam logic [7:0] SPACE_CODE = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_WRITE      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef struct packed {
    op_t                    operation;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
    logic [7:0]             character;
    logic                   string_start;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic [7:0] cell_char;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_READ
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_en;
    logic read_done;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic pos_bad;
    logic scroll;
    logic sweep_last;
  } dp_stat_t;

endpackage

### rtl/text_mode_char_buffer_core.sv
`timescale 1ns / 1ps
// Text-mode character buffer: ROWS x COLS cells with stored cursor and scroll.
// Each accepted word is answered from the result register; an in-range read
// cell first waits on the registered memory read port. Throughput: one word a
// cycle while the result register is free, but an in-range read holds input
// until its cell is loaded, a scrolling write while one row is blanked, and
// clear while the whole memory is. Reset: synchronous, then a full clearing pass.
module text_mode_char_buffer_core #(
  parameter int ROWS = tmcb_pkg::ROWS_DEFAULT,
  parameter int COLS = tmcb_pkg::COLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmcb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tmcb_pkg::out_word_t out_word
);

  // The controller sequences each word:
  //  - idle: take a word when the result register is free or being emptied;
  //  - sweep: blank memory one cell a cycle (reset, clear, or the row freed by
  //    a scroll);
  //  - read: drop the registered memory data into the result register.
  // The datapath holds the character memory as a ring of physical rows, so a
  // scroll only bumps the row offset and blanks one row.

  tmcb_pkg::dp_cmd_t  cmd;
  tmcb_pkg::dp_stat_t stat;

  tmcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (in_word.operation),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tmcb_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### rtl/tmcb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the character buffer: accepts words, runs sweeps and reads.
// Depends on tmcb_pkg.
module tmcb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tmcb_pkg::op_t      operation,
  output logic               in_ready,
  output tmcb_pkg::dp_cmd_t  cmd,
  input  tmcb_pkg::dp_stat_t stat
);

  tmcb_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcb_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.sweep_en  = 1'b0;
    cmd.read_done = 1'b0;
    unique case (state)
      tmcb_pkg::ST_INIT, tmcb_pkg::ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_last) begin
          state_next = tmcb_pkg::ST_IDLE;
        end
      end
      tmcb_pkg::ST_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept) begin
          unique case (operation)
            tmcb_pkg::OP_CLEAR: state_next = tmcb_pkg::ST_SWEEP;
            tmcb_pkg::OP_WRITE: begin
              if (stat.scroll) begin
                state_next = tmcb_pkg::ST_SWEEP;
              end
            end
            tmcb_pkg::OP_READ: begin
              if (!stat.pos_bad) begin
                state_next = tmcb_pkg::ST_READ;
              end
            end
            default: state_next = tmcb_pkg::ST_IDLE;
          endcase
        end
      end
      tmcb_pkg::ST_READ: begin
        cmd.read_done = 1'b1;
        state_next    = tmcb_pkg::ST_IDLE;
      end
      default: state_next = tmcb_pkg::ST_INIT;
    endcase
  end

endmodule

### rtl/tmcb_datapath.sv
`timescale 1ns / 1ps
// Datapath: character memory, cursor and write position, row ring offset,
// sweep counter and output register. Depends on tmcb_pkg.
module tmcb_datapath #(
  parameter int ROWS = tmcb_pkg::ROWS_DEFAULT,
  parameter int COLS = tmcb_pkg::COLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  tmcb_pkg::in_word_t  in_word,
  input  tmcb_pkg::dp_cmd_t   cmd,
  output tmcb_pkg::dp_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output tmcb_pkg::out_word_t out_word
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS << COL_W;
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  logic [ROW_W-1:0]  top_row_offset, cursor_row, write_row;
  logic [COL_W-1:0]  cursor_col, write_col;
  logic [ADDR_W-1:0] sweep_addr, sweep_end;

  logic              is_write, is_clear, is_set;
  logic [ROW_W-1:0]  wr_row0, wr_row, rd_row;
  logic [COL_W-1:0]  wr_col0, wr_col, rd_col;
  logic [ROW_W:0]    wr_sum, rd_sum;
  logic [ROW_W-1:0]  wr_phys, rd_phys;
  logic [ADDR_W-1:0] wr_addr, rd_addr, mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_we;
  logic              row_bad, col_bad;

  always_comb begin
    is_write = in_word.operation == tmcb_pkg::OP_WRITE;
    is_clear = in_word.operation == tmcb_pkg::OP_CLEAR;
    is_set   = in_word.operation == tmcb_pkg::OP_SET_CURSOR;

    row_bad = {1'b0, in_word.row} >= (tmcb_pkg::ROW_FIELD_W + 1)'(ROWS);
    col_bad = {1'b0, in_word.col} >= (tmcb_pkg::COL_FIELD_W + 1)'(COLS);

    // Running position, reloaded from the cursor when a string starts
    wr_row0 = in_word.string_start ? cursor_row : write_row;
    wr_col0 = in_word.string_start ? cursor_col : write_col;
    wr_row  = ({1'b0, wr_row0} >= (ROW_W + 1)'(ROWS)) ? LAST_ROW : wr_row0;
    wr_col  = ({1'b0, wr_col0} >= (COL_W + 1)'(COLS)) ? '0 : wr_col0;

    // Logical row to physical row through the ring offset
    wr_sum  = {1'b0, wr_row} + {1'b0, top_row_offset};
    wr_phys = (wr_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(wr_sum - (ROW_W + 1)'(ROWS))
                                             : wr_sum[ROW_W-1:0];
    wr_addr = {wr_phys, wr_col};

    rd_row  = in_word.row[ROW_W-1:0];
    rd_col  = in_word.col[COL_W-1:0];
    rd_sum  = {1'b0, rd_row} + {1'b0, top_row_offset};
    rd_phys = (rd_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W + 1)'(ROWS))
                                             : rd_sum[ROW_W-1:0];
    rd_addr = {rd_phys, rd_col};

    mem_we    = cmd.sweep_en || (cmd.accept && is_write);
    mem_waddr = cmd.sweep_en ? sweep_addr : wr_addr;
    mem_wdata = cmd.sweep_en ? tmcb_pkg::SPACE_CODE : in_word.character;

    stat.out_free   = !out_valid || out_ready;
    stat.pos_bad    = row_bad || col_bad;
    stat.scroll     = (wr_col == LAST_COL) && (wr_row == LAST_ROW);
    stat.sweep_last = sweep_addr == sweep_end;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Screen state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_row_offset <= '0;
      cursor_row     <= '0;
      cursor_col     <= '0;
      write_row      <= '0;
      write_col      <= '0;
      sweep_addr     <= '0;
      sweep_end      <= LAST_ADDR;
    end else if (cmd.sweep_en) begin
      sweep_addr <= sweep_addr + 1'b1;
    end else if (cmd.accept) begin
      if (is_clear) begin
        top_row_offset <= '0;
        sweep_addr     <= '0;
        sweep_end      <= LAST_ADDR;
      end
      if (is_set && !stat.pos_bad) begin
        cursor_row <= rd_row;
        cursor_col <= rd_col;
      end
      if (is_write) begin
        if (wr_col == LAST_COL) begin
          write_col <= '0;
          write_row <= stat.scroll ? LAST_ROW : wr_row + 1'b1;
        end else begin
          write_col <= wr_col + 1'b1;
          write_row <= wr_row;
        end
        if (stat.scroll) begin
          // Old top row becomes the blank bottom row
          top_row_offset <= (top_row_offset == LAST_ROW) ? '0 : top_row_offset + 1'b1;
          sweep_addr     <= {top_row_offset, {COL_W{1'b0}}};
          sweep_end      <= {top_row_offset, LAST_COL};
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.read_done
                 || (cmd.accept && !(in_word.operation == tmcb_pkg::OP_READ
                                     && !stat.pos_bad))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_done) begin
      out_word.status    <= 1'b0;
      out_word.cell_char <= rd_data;
    end else if (cmd.accept) begin
      out_word.status    <= (is_set || in_word.operation == tmcb_pkg::OP_READ)
                            && stat.pos_bad;
      out_word.cell_char <= '0;
    end
  end

endmodule

### rtl/tmcb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the character buffer, bound to the top level.
// Depends on tmcb_pkg and text_mode_char_buffer_core_macros.svh.
`include "text_mode_char_buffer_core_macros.svh"

module tmcb_checker #(
  parameter int ROWS = tmcb_pkg::ROWS_DEFAULT,
  parameter int COLS = tmcb_pkg::COLS_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input tmcb_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input tmcb_pkg::out_word_t out_word
);

  logic in_acc;
  logic rd_bad;
  logic stalled;
  logic quick_op;
  logic out_blank;
  logic ok_word;
  logic fail_word;

  assign in_acc    = in_valid && in_ready;
  assign rd_bad    = in_word.operation == tmcb_pkg::OP_READ
                     && (({1'b0, in_word.row} >= (tmcb_pkg::ROW_FIELD_W + 1)'(ROWS))
                         || ({1'b0, in_word.col} >= (tmcb_pkg::COL_FIELD_W + 1)'(COLS)));
  assign stalled   = out_valid && !out_ready;
  assign quick_op  = in_acc && (in_word.operation == tmcb_pkg::OP_CLEAR
                                || in_word.operation == tmcb_pkg::OP_WRITE);
  assign out_blank = out_word.cell_char == 8'h00;
  assign ok_word   = out_valid && !out_word.status && out_blank;
  assign fail_word = out_valid && out_word.status;

  // Stalled result holds
  `TMCB_ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid && $stable(out_word), "stalled result moved")

  // Clear and write answer success with no character on the next cycle
  `TMCB_ASSERT_NEXT(a_quick_ok, clk, rst, quick_op, ok_word, "clear or write result wrong")

  // Out-of-range read is flagged as failed in the result register, without a memory read
  `TMCB_ASSERT_NEXT(a_read_bad, clk, rst, in_acc && rd_bad, fail_word, "out-of-range read not flagged")

  // A failed word never carries a character
  `TMCB_ASSERT_NOW(a_fail_blank, clk, rst, fail_word, out_blank, "failure with character")

endmodule

bind text_mode_char_buffer_core tmcb_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tmcb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
